>>> hw/rtl/ealct_pkg.sv
// types, character codes and the escape phase step function for the last char tracker
`timescale 1ns / 1ps
`default_nettype none

package ealct_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SS3   = 8'h4F;
	localparam logic [7:0] CH_VT52Y = 8'h59;
	localparam logic [7:0] CH_LBRK  = 8'h5B;

	localparam logic [7:0] INTER_LO = 8'd32;
	localparam logic [7:0] INTER_HI = 8'd47;
	localparam logic [7:0] PARAM_LO = 8'd48;
	localparam logic [7:0] PARAM_HI = 8'd63;
	localparam logic [7:0] FINAL_LO = 8'd64;
	localparam logic [7:0] PRINT_HI = 8'd126;

	// configuration register indexes
	localparam logic CFG_INTERPRET = 1'b0;
	localparam logic CFG_DISCARD   = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_INTER = 3'd1,
		PH_CSI   = 3'd2,
		PH_SS3   = 3'd3,
		PH_ROW   = 3'd4,
		PH_COL   = 3'd5
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic   cont;
	} esc_step_t;

	// one recogniser step; checks cascade from the current phase through the later ones
	function automatic esc_step_t esc_advance(input phase_t ph, input logic [7:0] c);
		esc_step_t r;
		logic      done;
		r.phase = ph;
		r.cont  = 1'b0;
		done    = 1'b0;
		if (ph > PH_COL) begin
			r.phase = PH_IDLE;
			done    = 1'b1;
		end
		if (!done && ph <= PH_IDLE) begin
			if (c == CH_QUERY || c == CH_SEMI) begin
				r.phase = PH_INTER; r.cont = 1'b1; done = 1'b1;
			end else if (c == CH_SS3) begin
				r.phase = PH_SS3; r.cont = 1'b1; done = 1'b1;
			end else if (c == CH_VT52Y) begin
				r.phase = PH_ROW; r.cont = 1'b1; done = 1'b1;
			end else if (c == CH_LBRK) begin
				r.phase = PH_CSI; r.cont = 1'b1; done = 1'b1;
			end
		end
		if (!done && ph <= PH_INTER) begin
			if (c inside {[INTER_LO:INTER_HI]}) begin
				r.phase = PH_INTER; r.cont = 1'b1; done = 1'b1;
			end else if (c inside {[PARAM_LO:PRINT_HI]}) begin
				r.phase = PH_IDLE; done = 1'b1;
			end
		end
		if (!done && ph <= PH_CSI) begin
			if (c inside {[PARAM_LO:PARAM_HI]}) begin
				r.phase = PH_CSI; r.cont = 1'b1; done = 1'b1;
			end
		end
		if (!done && ph <= PH_SS3) begin
			if (c inside {[INTER_LO:INTER_HI]}) begin
				r.phase = PH_SS3; r.cont = 1'b1; done = 1'b1;
			end else if (c inside {[FINAL_LO:PRINT_HI]}) begin
				r.phase = PH_IDLE; done = 1'b1;
			end
		end
		if (!done && ph <= PH_ROW) begin
			if (c inside {[INTER_LO:PRINT_HI]}) begin
				r.phase = PH_COL; r.cont = 1'b1; done = 1'b1;
			end
		end
		if (!done && (c inside {[INTER_LO:PRINT_HI]})) begin
			r.phase = PH_IDLE;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/escape_aware_last_char_tracker_unit.sv
// top level of the escape aware last character tracker
`timescale 1ns / 1ps
`default_nettype none

// follows the byte stream sent to a terminal, one byte per transaction, and reports after
// every byte the last significant character, the escape recogniser state and whether a line
// feed must follow (tracked character is a carriage return). each accepted byte gives exactly
// one result transaction. a byte is captured in an input register (_s1); when the result
// register is free or being taken, short logic applies it to the tracker state and loads the
// result register. the design takes one byte per clock cycle for as long as results are taken.
// configuration (escape interpret mode, discard mode) is written through a plain write port
// and must only change while no transaction is in flight.
module escape_aware_last_char_tracker_unit
	import ealct_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic       cfg_wdata,
	// byte stream in
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] out_byte,
	input  wire logic       first_of_write,
	input  wire logic       last_of_write,
	// result out
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      tracked_char,
	output logic            inside_escape,
	output logic [2:0]      escape_phase,
	output logic            needs_line_feed
);

	// configuration registers
	logic       interpret_q;
	logic       discard_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;

	// tracker state
	logic [7:0] last_sig_q;
	logic       esc_active_q;
	phase_t     phase_q;

	// result register
	logic       res_valid_q;

	// next state
	logic [7:0] last_sig_d;
	logic       esc_active_d;
	phase_t     phase_d;
	logic       act_base;
	phase_t     ph_base;
	esc_step_t  step;
	logic       lone;

	logic       advance;

	// byte moves from the input register into the result register
	assign advance  = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interpret_q <= 1'b0;
			discard_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_INTERPRET: interpret_q <= cfg_wdata;
				CFG_DISCARD:   discard_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register; payload needs no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= out_byte;
			first_s1 <= first_of_write;
			last_s1  <= last_of_write;
		end
	end

	// tracker update for the byte in the input register
	always_comb begin
		// a write opens with the escape recogniser restarted
		act_base = first_s1 ? 1'b0 : esc_active_q;
		ph_base  = first_s1 ? PH_IDLE : phase_q;
		step     = esc_advance(ph_base, byte_s1);
		lone     = first_s1 && last_s1;

		last_sig_d   = last_sig_q;
		esc_active_d = esc_active_q;
		phase_d      = phase_q;

		if (!discard_q) begin
			esc_active_d = act_base;
			phase_d      = ph_base;
			if (lone && byte_s1 == CH_NUL) begin
				// lone nul only restarts the recogniser
			end else if (lone && byte_s1 == CH_FF) begin
				last_sig_d = CH_FF;
			end else if (interpret_q) begin
				if (last_s1) begin
					last_sig_d = byte_s1;
				end
			end else if (byte_s1 == CH_ESC) begin
				// esc inside a sequence keeps the phase as it was
				esc_active_d = 1'b1;
			end else if (act_base) begin
				phase_d      = step.phase;
				esc_active_d = step.cont;
			end else if (byte_s1 != CH_NUL) begin
				last_sig_d = byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sig_q   <= 8'h00;
			esc_active_q <= 1'b0;
			phase_q      <= PH_IDLE;
		end else if (advance) begin
			last_sig_q   <= last_sig_d;
			esc_active_q <= esc_active_d;
			phase_q      <= phase_d;
		end
	end

	// result register, freed whenever the far side takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tracked_char    <= last_sig_d;
			inside_escape   <= esc_active_d;
			escape_phase    <= phase_d;
			needs_line_feed <= (last_sig_d == CH_CR);
		end
	end

	assign out_valid = res_valid_q;

	// line feed flag agrees with the character it refers to
	a_lf_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (needs_line_feed == (tracked_char == CH_CR)))
		else $error("line feed flag does not match tracked character");

	// result matches the tracker state it was taken from
	a_res_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (tracked_char == last_sig_q && inside_escape == esc_active_q
			&& escape_phase == phase_q))
		else $error("result register out of step with tracker state");

	// discard mode freezes the tracker
	a_discard_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && discard_q) |=> ($stable(last_sig_q) && $stable(esc_active_q)
			&& $stable(phase_q)))
		else $error("tracker state changed in discard mode");

	// an empty input register always takes a byte
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input register empty but not ready");

	// both registers full and result stalled: no new byte
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid_q && !out_ready) |-> !in_ready)
		else $error("byte accepted while pipeline is full");

endmodule

`default_nettype wire

>>> dv/tb_escape_aware_last_char_tracker_unit.sv
// self-checking testbench for the escape aware last character tracker
`timescale 1ns / 1ps

module tb_escape_aware_last_char_tracker_unit;
	import ealct_pkg::*;

	// status reported after every byte, in the order the result transaction carries it
	typedef struct packed {
		logic [7:0] ch;
		logic       esc;
		phase_t     ph;
		logic       lf;
	} tracker_status_t;

	// one line of the directed walk; want only counts where typed is set
	typedef struct packed {
		logic [7:0]      b;
		logic            f;
		logic            l;
		logic            interp;
		logic            discard;
		logic            typed;
		tracker_status_t want;
	} dir_row_t;

	typedef struct packed {
		logic interp;
		logic discard;
	} cfg_setting_t;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam tracker_status_t UNTYPED = '0;
	localparam int N_DIR = 29;

	// directed walk: extremes first, then each recogniser form, then both modes
	localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
		// lone nul straight after reset leaves everything at zero
		'{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, '{8'h00, 1'b0, PH_IDLE, 1'b0}},
		'{8'h41, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, '{8'h41, 1'b0, PH_IDLE, 1'b0}},
		'{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, '{8'hFF, 1'b0, PH_IDLE, 1'b0}},
		// carriage return asks for a line feed
		'{CH_CR, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, '{CH_CR, 1'b0, PH_IDLE, 1'b1}},
		// lone form feed
		'{CH_FF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, '{CH_FF, 1'b0, PH_IDLE, 1'b0}},
		// esc opens a sequence and keeps the tracked character
		'{CH_ESC, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, '{CH_FF, 1'b1, PH_IDLE, 1'b0}},
		// csi with a final byte
		'{CH_LBRK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UNTYPED},
		'{8'h6D, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, UNTYPED},
		// vt52 cursor address with a column byte above 126: phase stays at column
		'{CH_ESC, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, UNTYPED},
		'{CH_VT52Y, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UNTYPED},
		'{8'h20, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UNTYPED},
		'{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UNTYPED},
		'{8'h5A, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, UNTYPED},
		// ss3 with an esc inside the sequence
		'{CH_ESC, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, UNTYPED},
		'{CH_SS3, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UNTYPED},
		'{CH_ESC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UNTYPED},
		'{8'h50, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, UNTYPED},
		// intermediate form ended by the top printable byte
		'{CH_ESC, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, UNTYPED},
		'{CH_QUERY, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UNTYPED},
		'{8'h7E, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, UNTYPED},
		// nul inside a longer write, then a write without its opening flag
		'{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, UNTYPED},
		'{CH_ESC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, UNTYPED},
		'{8'h7F, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, UNTYPED},
		// interpret mode: only the closing byte of a write is tracked
		'{8'h41, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, UNTYPED},
		'{8'h42, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, '{8'h42, 1'b0, PH_IDLE, 1'b0}},
		'{CH_FF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, '{CH_FF, 1'b0, PH_IDLE, 1'b0}},
		'{CH_NUL, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, '{CH_FF, 1'b0, PH_IDLE, 1'b0}},
		'{CH_ESC, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, '{CH_ESC, 1'b0, PH_IDLE, 1'b0}},
		// discard mode freezes the lot
		'{8'h55, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, '{CH_ESC, 1'b0, PH_IDLE, 1'b0}}
	};

	// register settings the random part cycles through, extremes included
	localparam cfg_setting_t CFG_SEQ [0:4] = '{
		'{1'b0, 1'b0}, '{1'b1, 1'b0}, '{1'b0, 1'b1}, '{1'b0, 1'b0}, '{1'b1, 1'b1}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] out_byte = 8'h00;
	logic       first_of_write = 1'b0;
	logic       last_of_write = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] tracked_char;
	logic       inside_escape;
	logic [2:0] escape_phase;
	logic       needs_line_feed;

	// predictor copy of the tracker state and its registers
	logic [7:0] trk_char = 8'h00;
	logic       trk_esc = 1'b0;
	phase_t     trk_phase = PH_IDLE;
	logic       cfg_interpret = 1'b0;
	logic       cfg_discard = 1'b0;

	// predicted status per accepted byte, oldest first
	tracker_status_t tracker_status_q [$];
	tracker_status_t want_status;
	logic [7:0]      write_bytes [$];
	int              errors = 0;
	int              send_idle_pct = 0;
	int              recv_stall_pct = 0;

	escape_aware_last_char_tracker_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.out_byte       (out_byte),
		.first_of_write (first_of_write),
		.last_of_write  (last_of_write),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.tracked_char   (tracked_char),
		.inside_escape  (inside_escape),
		.escape_phase   (escape_phase),
		.needs_line_feed(needs_line_feed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// one recogniser step; returns 1 while the sequence goes on. each phase also falls
	// into the checks of the later phases, so a csi intermediate lands in ss3 and an ss3
	// parameter byte jumps to the vt52 column
	function automatic logic escape_step(input phase_t cur, input logic [7:0] c,
			output phase_t nxt);
		logic is_inter;
		logic is_param;
		logic is_final;
		logic is_print;
		logic cont;
		is_inter = c >= INTER_LO && c <= INTER_HI;
		is_param = c >= PARAM_LO && c <= PARAM_HI;
		is_final = c >= FINAL_LO && c <= PRINT_HI;
		is_print = c >= INTER_LO && c <= PRINT_HI;
		nxt = cur;
		cont = 1'b0;
		case (cur)
			PH_IDLE: begin
				if (c == CH_QUERY || c == CH_SEMI || is_inter)
					nxt = PH_INTER;
				else if (c == CH_SS3)
					nxt = PH_SS3;
				else if (c == CH_VT52Y)
					nxt = PH_ROW;
				else if (c == CH_LBRK)
					nxt = PH_CSI;
				cont = nxt != PH_IDLE;
			end
			PH_INTER: begin
				cont = is_inter;
				if (is_print && !is_inter)
					nxt = PH_IDLE;
			end
			PH_CSI: begin
				if (is_param) begin
					cont = 1'b1;
				end else if (is_inter) begin
					nxt = PH_SS3;
					cont = 1'b1;
				end else if (is_final) begin
					nxt = PH_IDLE;
				end
			end
			PH_SS3: begin
				if (is_inter) begin
					cont = 1'b1;
				end else if (is_final) begin
					nxt = PH_IDLE;
				end else if (is_param) begin
					nxt = PH_COL;
					cont = 1'b1;
				end
			end
			PH_ROW: begin
				if (is_print) begin
					nxt = PH_COL;
					cont = 1'b1;
				end
			end
			PH_COL: begin
				// out of range column bytes end the sequence but leave the phase here
				if (is_print)
					nxt = PH_IDLE;
			end
			default: nxt = PH_IDLE;
		endcase
		return cont;
	endfunction

	// advances the predicted tracker by one byte and returns the status after it
	function automatic tracker_status_t apply_byte(input logic [7:0] c, input logic f,
			input logic l);
		tracker_status_t s;
		phase_t          nxt;
		logic            cont;
		if (!cfg_discard) begin
			if (f) begin
				trk_esc = 1'b0;
				trk_phase = PH_IDLE;
			end
			if (f && l && c == CH_NUL) begin
				// lone nul only restarts escape tracking
			end else if (f && l && c == CH_FF) begin
				trk_char = CH_FF;
			end else if (cfg_interpret) begin
				if (l)
					trk_char = c;
			end else if (c == CH_ESC) begin
				// also inside a sequence: stays active, phase untouched
				trk_esc = 1'b1;
			end else begin
				if (!trk_esc && c != CH_NUL)
					trk_char = c;
				if (trk_esc) begin
					cont = escape_step(trk_phase, c, nxt);
					trk_phase = nxt;
					if (!cont)
						trk_esc = 1'b0;
				end
			end
		end
		s.ch = trk_char;
		s.esc = trk_esc;
		s.ph = trk_phase;
		s.lf = trk_char == CH_CR;
		return s;
	endfunction

	task automatic check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
			errors++;
		end
	endtask

	// result side: compare every result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (tracker_status_q.size() == 0) begin
				$display("%0t: result transaction with nothing expected, expected none actual %0h",
					$time, tracked_char);
				errors++;
			end else begin
				want_status = tracker_status_q.pop_front();
				check_field("tracked_char", want_status.ch, tracked_char);
				check_field("inside_escape", {7'd0, want_status.esc}, {7'd0, inside_escape});
				check_field("escape_phase", {5'd0, want_status.ph}, {5'd0, escape_phase});
				check_field("needs_line_feed", {7'd0, want_status.lf}, {7'd0, needs_line_feed});
			end
		end
		out_ready <= $urandom_range(99) >= recv_stall_pct;
	end

	task automatic set_idling(input idle_mode_t m);
		case (m)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 79;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 79;
			end
			default: begin
				send_idle_pct = 38;
				recv_stall_pct = 38;
			end
		endcase
	endtask

	// one byte transaction; valid stays high straight into the next byte when there is no gap
	task automatic send_byte(input logic [7:0] b, input logic f, input logic l,
			input logic typed, input tracker_status_t typed_want);
		int              gap;
		tracker_status_t predicted;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		out_byte <= b;
		first_of_write <= f;
		last_of_write <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = apply_byte(b, f, l);
		tracker_status_q.push_back(typed ? typed_want : predicted);
	endtask

	// hold the sender off until every predicted result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (tracker_status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// leaves cfg_we high so back-to-back writes never lower and raise it in one step
	task automatic write_reg(input logic idx, input logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == CFG_INTERPRET)
			cfg_interpret = val;
		else
			cfg_discard = val;
	endtask

	task automatic set_mode(input cfg_setting_t s);
		drain_results();
		write_reg(CFG_INTERPRET, s.interp);
		write_reg(CFG_DISCARD, s.discard);
		cfg_we <= 1'b0;
	endtask

	// builds one write into write_bytes: text, controls and escape forms, some broken
	function automatic void build_write();
		int kind;
		int pieces;
		int k;
		write_bytes.delete();
		kind = $urandom_range(99);
		if (kind < 8) begin
			write_bytes.push_back(CH_NUL);
		end else if (kind < 14) begin
			write_bytes.push_back(CH_FF);
		end else if (kind < 20) begin
			write_bytes.push_back(8'($urandom_range(255)));
		end else begin
			pieces = $urandom_range(4, 1);
			repeat (pieces) begin
				k = $urandom_range(9);
				case (k)
					0, 1: repeat ($urandom_range(5, 1))
						write_bytes.push_back(8'($urandom_range(PRINT_HI, INTER_LO)));
					2: begin
						write_bytes.push_back(CH_CR);
						if ($urandom_range(1))
							write_bytes.push_back(CH_LF);
					end
					3: begin
						write_bytes.push_back(CH_ESC);
						write_bytes.push_back(CH_LBRK);
						repeat ($urandom_range(3))
							write_bytes.push_back(8'($urandom_range(PARAM_HI, PARAM_LO)));
						write_bytes.push_back(8'($urandom_range(PRINT_HI, FINAL_LO)));
					end
					4: begin
						write_bytes.push_back(CH_ESC);
						write_bytes.push_back(CH_SS3);
						repeat ($urandom_range(1))
							write_bytes.push_back(8'($urandom_range(INTER_HI, INTER_LO)));
						write_bytes.push_back(8'($urandom_range(PRINT_HI, FINAL_LO)));
					end
					5: begin
						write_bytes.push_back(CH_ESC);
						write_bytes.push_back(CH_VT52Y);
						write_bytes.push_back(8'($urandom_range(PRINT_HI, INTER_LO)));
						if ($urandom_range(3) == 0)
							write_bytes.push_back(8'($urandom_range(255)));
						else
							write_bytes.push_back(8'($urandom_range(PRINT_HI, INTER_LO)));
					end
					6: begin
						write_bytes.push_back(CH_ESC);
						case ($urandom_range(2))
							0: write_bytes.push_back(CH_QUERY);
							1: write_bytes.push_back(CH_SEMI);
							default: write_bytes.push_back(8'($urandom_range(INTER_HI, INTER_LO)));
						endcase
						repeat ($urandom_range(2))
							write_bytes.push_back(8'($urandom_range(INTER_HI, INTER_LO)));
						write_bytes.push_back(8'($urandom_range(PRINT_HI, PARAM_LO)));
					end
					7: begin
						// broken sequence: esc followed by anything
						write_bytes.push_back(CH_ESC);
						repeat ($urandom_range(3, 1))
							write_bytes.push_back(8'($urandom_range(255)));
					end
					8: repeat ($urandom_range(3, 1))
						write_bytes.push_back(8'($urandom_range(255)));
					default: write_bytes.push_back(8'($urandom_range(8'h1F)));
				endcase
			end
		end
	endfunction

	initial begin
		automatic int   counted = 0;
		automatic int   phase_no = 0;
		int             quota;
		int             n;
		logic           f;
		logic           l;
		logic           noisy;
		cfg_setting_t   s;
		dir_row_t       row;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed walk
		set_idling(IDLE_NONE);
		for (int i = 0; i < N_DIR; i++) begin
			row = DIR_ROWS[i];
			if (row.interp !== cfg_interpret || row.discard !== cfg_discard) begin
				s.interp = row.interp;
				s.discard = row.discard;
				set_mode(s);
			end
			send_byte(row.b, row.f, row.l, row.typed, row.want);
		end

		// random writes; discard phases are kept short
		while (counted < 1900) begin
			set_idling(idle_mode_t'(phase_no % 4));
			s = CFG_SEQ[phase_no % 5];
			set_mode(s);
			quota = s.discard ? 40 : 250;
			n = 0;
			while (n < quota) begin
				build_write();
				// now and then the flags are scrambled: missing opens, early closes
				noisy = $urandom_range(99) < 8;
				for (int k = 0; k < write_bytes.size(); k++) begin
					f = noisy ? 1'($urandom_range(1)) : (k == 0);
					l = noisy ? 1'($urandom_range(1)) : (k == write_bytes.size() - 1);
					send_byte(write_bytes[k], f, l, 1'b0, UNTYPED);
				end
				n += write_bytes.size();
				counted += write_bytes.size();
				// now and then the sender waits for the result side to empty completely
				if ($urandom_range(199) == 0)
					drain_results();
			end
			phase_no++;
		end

		drain_results();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
